// ===== hdl/accel_tilt_angle_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Accelerometer tilt unit - assertion macros
// Concurrent checks that vanish when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ACCEL_TILT_ANGLE_UNIT_ASSERT_SVH
`define ACCEL_TILT_ANGLE_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define ATU_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tilt unit: same-cycle check failed");

// next-cycle implication
`define ATU_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tilt unit: next-cycle check failed");

`else

`define ATU_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define ATU_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== hdl/atilt_pkg.sv =====
// ----------------------------------------------------------------------------
// Accelerometer tilt unit - shared package
// Widths, constants, stage-advance struct and the asin table generator.
// ----------------------------------------------------------------------------
package atilt_pkg;

    localparam int AsinTableBits = 10;

    localparam int RawW   = 16;
    localparam int MilliW = 12;
    localparam int TiltW  = 11;
    localparam int RomW   = 18;          // table entries in 1/256 tenth degree

    localparam int OneG       = 16384;   // counts per g
    localparam int AngleFull  = 230400;  // 90 degrees in table units
    localparam int TiltMax    = 900;
    localparam int MilliScale = 1000;
    localparam int MilliRound = 8192;
    localparam int MilliShift = 14;
    localparam int RoundHalf  = 128;
    localparam int RoundShift = 8;

    localparam int SineTerms   = 10;
    localparam int BisectSteps = 20;
    localparam int DivBits     = 34;     // series terms stay below 2^33
    localparam logic [63:0] RadPerUnitQ48 = 64'd1919009807;

    // per-stage advance enables of the lane pipeline
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } t_adv;

    // shift-and-subtract quotient, elaboration time only
    function automatic logic [63:0] udiv_small(input logic [63:0] num,
                                               input logic [63:0] den);
        logic [63:0] q;
        logic [63:0] rem;
        q   = '0;
        rem = '0;
        for (int b = DivBits - 1; b >= 0; b--) begin
            rem = {rem[62:0], num[b]};
            if (rem >= den) begin
                rem  = rem - den;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // sine in Q30 of an angle in table units, truncated Taylor series
    function automatic logic [63:0] sine_q30(input logic [63:0] a);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic [63:0]        den;
        logic signed [63:0] sum;
        x    = (a * RadPerUnitQ48) >> 18;
        x2   = (x * x) >> 30;
        term = x;
        sum  = signed'(x);
        for (int n = 1; n <= SineTerms; n++) begin
            term = (term * x2) >> 30;
            den  = 64'((2 * n) * (2 * n + 1));
            term = udiv_small(term, den);
            if ((n & 1) != 0) begin
                sum = sum - signed'(term);
            end else begin
                sum = sum + signed'(term);
            end
        end
        return (sum < 0) ? 64'd0 : unsigned'(sum);
    endfunction

    // largest angle whose sine does not exceed idx / 2^bits
    function automatic logic [RomW-1:0] asin_entry(input int unsigned idx,
                                                   input int unsigned bits);
        logic [63:0] target;
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] mid;
        target = 64'(idx) << (30 - bits);
        lo     = 32'd0;
        hi     = 32'(AngleFull);
        for (int it = 0; it < BisectSteps; it++) begin
            if (lo < hi) begin
                mid = (lo + hi + 32'd1) >> 1;
                if (sine_q30(64'(mid)) <= target) begin
                    lo = mid;
                end else begin
                    hi = mid - 32'd1;
                end
            end
        end
        if (idx == (32'd1 << bits)) begin
            lo = 32'(AngleFull);
        end
        return lo[RomW-1:0];
    endfunction

endpackage

// ===== hdl/atilt_if.sv =====
// ----------------------------------------------------------------------------
// Accelerometer tilt unit - channel interfaces
// Valid/ready sample and result channels.
// ----------------------------------------------------------------------------
interface atilt_sample_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [atilt_pkg::RawW-1:0]     accel_x;
    logic signed [atilt_pkg::RawW-1:0]     accel_y;
    logic signed [atilt_pkg::RawW-1:0]     accel_z;

    modport source (output valid, output accel_x, output accel_y, output accel_z,
                    input ready);
    modport sink   (input valid, input accel_x, input accel_y, input accel_z,
                    output ready);
endinterface

interface atilt_result_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [atilt_pkg::MilliW-1:0]   x_milli_g;
    logic signed [atilt_pkg::MilliW-1:0]   y_milli_g;
    logic signed [atilt_pkg::MilliW-1:0]   z_milli_g;
    logic signed [atilt_pkg::TiltW-1:0]    tilt_x_tenths;
    logic signed [atilt_pkg::TiltW-1:0]    tilt_y_tenths;

    modport source (output valid, output x_milli_g, output y_milli_g, output z_milli_g,
                    output tilt_x_tenths, output tilt_y_tenths, input ready);
    modport sink   (input valid, input x_milli_g, input y_milli_g, input z_milli_g,
                    input tilt_x_tenths, input tilt_y_tenths, output ready);
endinterface

// ===== hdl/atilt_ram.sv =====
// ----------------------------------------------------------------------------
// Accelerometer tilt unit - generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module atilt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [$clog2(DEPTH)-1:0]   i_waddr,
    input  logic [WIDTH-1:0]           i_wdata,
    input  logic                       i_re,
    input  logic [$clog2(DEPTH)-1:0]   i_raddr,
    output logic [WIDTH-1:0]           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/atilt_rom_load.sv =====
// ----------------------------------------------------------------------------
// Accelerometer tilt unit - asin table loader
// Sweeps the elaborated asin table into the lane RAMs after reset.
// ----------------------------------------------------------------------------
module atilt_rom_load #(
    parameter int ASIN_TABLE_BITS = atilt_pkg::AsinTableBits
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    output logic                          o_wr_even,
    output logic                          o_wr_odd,
    output logic [ASIN_TABLE_BITS-1:0]    o_wr_addr,
    output logic [atilt_pkg::RomW-1:0]    o_wr_data,
    output logic                          o_loaded
);

    localparam int RomLen = (1 << ASIN_TABLE_BITS) + 1;
    localparam int CntW   = ASIN_TABLE_BITS + 1;

    logic [atilt_pkg::RomW-1:0] w_rom [RomLen];

    for (genvar g = 0; g < RomLen; g++) begin : g_rom
        localparam logic [atilt_pkg::RomW-1:0] Entry =
            atilt_pkg::asin_entry(g, ASIN_TABLE_BITS);
        assign w_rom[g] = Entry;
    end

    logic [CntW-1:0] r_cnt, n_cnt;
    logic            r_loaded, n_loaded;

    always_comb begin
        n_cnt    = r_cnt;
        n_loaded = r_loaded;
        if (!r_loaded) begin
            if (r_cnt == CntW'(RomLen - 1)) begin
                n_loaded = 1'b1;
            end else begin
                n_cnt = r_cnt + CntW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_loaded <= 1'b0;
        end else begin
            r_cnt    <= n_cnt;
            r_loaded <= n_loaded;
        end
    end

    // even entries to the even bank, odd to the odd bank, both at index/2
    assign o_wr_even = !r_loaded && !r_cnt[0];
    assign o_wr_odd  = !r_loaded &&  r_cnt[0];
    assign o_wr_addr = r_cnt[CntW-1:1];
    assign o_wr_data = w_rom[r_cnt];
    assign o_loaded  = r_loaded;

endmodule

// ===== hdl/atilt_milli.sv =====
// ----------------------------------------------------------------------------
// Accelerometer tilt unit - milli-g lane
// raw * 1000 / 16384, rounded half away from zero.
// ----------------------------------------------------------------------------
module atilt_milli (
    input  logic                                 i_clk,
    input  atilt_pkg::t_adv                      i_adv,
    input  logic signed [atilt_pkg::RawW-1:0]    i_raw,
    output logic signed [atilt_pkg::MilliW-1:0]  o_milli
);

    localparam int ProdW = 25;   // 32768 * 1000 + rounding fits

    logic [atilt_pkg::RawW-1:0] w_abs;
    logic                       r_neg1, r_neg2;
    logic [atilt_pkg::RawW-1:0] r_mag1;
    logic [ProdW-1:0]           r_prod2;
    logic [ProdW-1:0]           w_round;
    logic [atilt_pkg::MilliW-1:0] w_m;

    assign w_abs = i_raw[atilt_pkg::RawW-1] ?
                   (atilt_pkg::RawW'(0) - unsigned'(i_raw)) : unsigned'(i_raw);

    always_ff @(posedge i_clk) begin
        if (i_adv.s1) begin
            r_neg1 <= i_raw[atilt_pkg::RawW-1];
            r_mag1 <= w_abs;
        end
        if (i_adv.s2) begin
            r_neg2  <= r_neg1;
            r_prod2 <= ProdW'(r_mag1) * ProdW'(atilt_pkg::MilliScale);
        end
    end

    assign w_round = r_prod2 + ProdW'(atilt_pkg::MilliRound);
    assign w_m     = atilt_pkg::MilliW'(w_round >> atilt_pkg::MilliShift);
    assign o_milli = r_neg2 ? (atilt_pkg::MilliW'(0) - signed'(w_m)) : signed'(w_m);

endmodule

// ===== hdl/atilt_asin.sv =====
// ----------------------------------------------------------------------------
// Accelerometer tilt unit - tilt lane
// Clamp to one g, banked asin table lookup, linear interpolation, rounding.
// ----------------------------------------------------------------------------
module atilt_asin #(
    parameter int ASIN_TABLE_BITS = atilt_pkg::AsinTableBits
) (
    input  logic                                 i_clk,
    input  atilt_pkg::t_adv                      i_adv,
    input  logic                                 i_wr_even,
    input  logic                                 i_wr_odd,
    input  logic [ASIN_TABLE_BITS-1:0]           i_wr_addr,
    input  logic [atilt_pkg::RomW-1:0]           i_wr_data,
    input  logic signed [atilt_pkg::RawW-1:0]    i_raw,
    output logic signed [atilt_pkg::TiltW-1:0]   o_tilt
);

    localparam int B         = ASIN_TABLE_BITS;
    localparam int Shift     = 14 - B;
    localparam int FracW     = (Shift > 0) ? Shift : 1;
    localparam int IdxW      = B + 1;
    localparam int MagW      = 15;
    localparam int EvenDepth = (1 << (B - 1)) + 1;
    localparam int OddDepth  = 1 << (B - 1);
    localparam int RomW      = atilt_pkg::RomW;

    logic [atilt_pkg::RawW-1:0] w_abs;
    logic [MagW-1:0]            w_mag;
    logic [IdxW-1:0]            w_idx;
    logic [FracW-1:0]           w_frac;
    logic [B-1:0]               w_even_addr;
    logic [B-2:0]               w_odd_addr;
    logic [RomW-1:0]            w_even_q, w_odd_q;

    assign w_abs = i_raw[atilt_pkg::RawW-1] ?
                   (atilt_pkg::RawW'(0) - unsigned'(i_raw)) : unsigned'(i_raw);
    assign w_mag = (w_abs > atilt_pkg::RawW'(atilt_pkg::OneG)) ?
                   MagW'(atilt_pkg::OneG) : w_abs[MagW-1:0];
    assign w_idx  = IdxW'(w_mag >> Shift);
    assign w_frac = (Shift > 0) ? w_mag[FracW-1:0] : '0;

    // T[2k] sits in the even bank at k, T[2k+1] in the odd bank at k
    assign w_even_addr = w_idx[IdxW-1:1] + B'(w_idx[0]);
    assign w_odd_addr  = w_idx[B-1:1];

    atilt_ram #(.WIDTH(RomW), .DEPTH(EvenDepth)) u_even (
        .i_clk   (i_clk),
        .i_we    (i_wr_even),
        .i_waddr (i_wr_addr),
        .i_wdata (i_wr_data),
        .i_re    (i_adv.s1),
        .i_raddr (w_even_addr),
        .o_rdata (w_even_q)
    );

    atilt_ram #(.WIDTH(RomW), .DEPTH(OddDepth)) u_odd (
        .i_clk   (i_clk),
        .i_we    (i_wr_odd),
        .i_waddr (i_wr_addr[B-2:0]),
        .i_wdata (i_wr_data),
        .i_re    (i_adv.s1),
        .i_raddr (w_odd_addr),
        .o_rdata (w_odd_q)
    );

    logic                 r_neg1, r_swap1;
    logic [FracW-1:0]     r_frac1;
    logic [RomW-1:0]      w_lo, w_hi, w_diff;
    logic [RomW+FracW-1:0] w_prod;
    logic                 r_neg2;
    logic [RomW-1:0]      r_lo2, r_step2;
    logic [RomW:0]        w_v, w_round;
    logic [atilt_pkg::TiltW-1:0] w_t;

    always_ff @(posedge i_clk) begin
        if (i_adv.s1) begin
            r_neg1  <= i_raw[atilt_pkg::RawW-1];
            r_swap1 <= w_idx[0];
            r_frac1 <= w_frac;
        end
        if (i_adv.s2) begin
            r_neg2  <= r_neg1;
            r_lo2   <= w_lo;
            r_step2 <= RomW'(w_prod >> Shift);
        end
    end

    // odd index: lower point from the odd bank, upper from the even one
    assign w_lo   = r_swap1 ? w_odd_q  : w_even_q;
    assign w_hi   = r_swap1 ? w_even_q : w_odd_q;
    assign w_diff = w_hi - w_lo;
    assign w_prod = (RomW + FracW)'(w_diff) * (RomW + FracW)'(r_frac1);

    assign w_v     = (RomW + 1)'(r_lo2) + (RomW + 1)'(r_step2);
    assign w_round = w_v + (RomW + 1)'(atilt_pkg::RoundHalf);
    assign w_t     = w_round[RomW:atilt_pkg::RoundShift];
    assign o_tilt  = r_neg2 ? (atilt_pkg::TiltW'(0) - signed'(w_t)) : signed'(w_t);

endmodule

// ===== hdl/accel_tilt_angle_unit.sv =====
// ----------------------------------------------------------------------------
// Accelerometer tilt unit - top level
// Three-axis sample in; milli-g per axis and X/Y tilt in tenths of a degree out.
//
// Usage:
//  - i_sample carries one raw sample (accel_x/y/z, 16384 counts per g); an
//    item moves when valid and ready are both high on a rising i_clk.
//  - o_result carries one result item per sample, in order.
//  - Items pass through stage 1, stage 2 and the output register to o_result.
//  - Throughput: one item per cycle while o_result is ready; five lanes (three
//    milli-g, two tilt) run side by side and the output register merges them.
//  - Each tilt lane reads two adjacent asin points per cycle from an even and
//    an odd RAM bank, so one read port per bank keeps the full rate.
//  - Reset (i_rst_n low, synchronous) empties the pipeline. The asin table is
//    then copied into the lane RAMs, one entry a cycle, all 2^ASIN_TABLE_BITS+1
//    entries (1025 at the default), with i_sample.ready low until it is done.
//  - When the receiver stalls, the held result stays on o_result and the
//    earlier stages keep filling; input ready drops only once all three
//    stages hold items.
// ----------------------------------------------------------------------------
`include "accel_tilt_angle_unit_assert.svh"

module accel_tilt_angle_unit #(
    parameter int ASIN_TABLE_BITS = atilt_pkg::AsinTableBits
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    atilt_sample_if.sink     i_sample,
    atilt_result_if.source   o_result
);

    // table load
    logic                          w_wr_even, w_wr_odd, w_loaded;
    logic [ASIN_TABLE_BITS-1:0]    w_wr_addr;
    logic [atilt_pkg::RomW-1:0]    w_wr_data;

    atilt_rom_load #(.ASIN_TABLE_BITS(ASIN_TABLE_BITS)) u_load (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .o_wr_even (w_wr_even),
        .o_wr_odd  (w_wr_odd),
        .o_wr_addr (w_wr_addr),
        .o_wr_data (w_wr_data),
        .o_loaded  (w_loaded)
    );

    // pipeline control: each stage moves when it is empty or the next moves
    atilt_pkg::t_adv w_adv;
    logic            r_v1, r_v2, r_v3;
    logic            w_in_fire;

    always_comb begin
        w_adv.s3 = !r_v3 || o_result.ready;
        w_adv.s2 = !r_v2 || w_adv.s3;
        w_adv.s1 = !r_v1 || w_adv.s2;
    end

    assign i_sample.ready = w_adv.s1 && w_loaded;
    assign w_in_fire      = i_sample.valid && i_sample.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_adv.s1) begin
                r_v1 <= w_in_fire;
            end
            if (w_adv.s2) begin
                r_v2 <= r_v1;
            end
            if (w_adv.s3) begin
                r_v3 <= r_v2;
            end
        end
    end

    // lanes
    logic signed [atilt_pkg::MilliW-1:0] w_x_milli, w_y_milli, w_z_milli;
    logic signed [atilt_pkg::TiltW-1:0]  w_tilt_x, w_tilt_y;

    atilt_milli u_milli_x (
        .i_clk (i_clk), .i_adv (w_adv), .i_raw (i_sample.accel_x), .o_milli (w_x_milli)
    );
    atilt_milli u_milli_y (
        .i_clk (i_clk), .i_adv (w_adv), .i_raw (i_sample.accel_y), .o_milli (w_y_milli)
    );
    atilt_milli u_milli_z (
        .i_clk (i_clk), .i_adv (w_adv), .i_raw (i_sample.accel_z), .o_milli (w_z_milli)
    );

    atilt_asin #(.ASIN_TABLE_BITS(ASIN_TABLE_BITS)) u_tilt_x (
        .i_clk     (i_clk),
        .i_adv     (w_adv),
        .i_wr_even (w_wr_even),
        .i_wr_odd  (w_wr_odd),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_raw     (i_sample.accel_x),
        .o_tilt    (w_tilt_x)
    );

    atilt_asin #(.ASIN_TABLE_BITS(ASIN_TABLE_BITS)) u_tilt_y (
        .i_clk     (i_clk),
        .i_adv     (w_adv),
        .i_wr_even (w_wr_even),
        .i_wr_odd  (w_wr_odd),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_raw     (i_sample.accel_y),
        .o_tilt    (w_tilt_y)
    );

    // merge: output register collects all five lanes
    logic signed [atilt_pkg::MilliW-1:0] r_x_milli, r_y_milli, r_z_milli;
    logic signed [atilt_pkg::TiltW-1:0]  r_tilt_x, r_tilt_y;

    always_ff @(posedge i_clk) begin
        if (w_adv.s3) begin
            r_x_milli <= w_x_milli;
            r_y_milli <= w_y_milli;
            r_z_milli <= w_z_milli;
            r_tilt_x  <= w_tilt_x;
            r_tilt_y  <= w_tilt_y;
        end
    end

    assign o_result.valid         = r_v3;
    assign o_result.x_milli_g     = r_x_milli;
    assign o_result.y_milli_g     = r_y_milli;
    assign o_result.z_milli_g     = r_z_milli;
    assign o_result.tilt_x_tenths = r_tilt_x;
    assign o_result.tilt_y_tenths = r_tilt_y;

    // checks
    `ATU_ASSERT_IMP(a_load_empty, i_clk, i_rst_n, $rose(w_loaded), !r_v1 && !r_v2 && !r_v3)
    `ATU_ASSERT_IMP(a_tilt_range, i_clk, i_rst_n, r_v3,
        (r_tilt_x <= atilt_pkg::TiltMax) && (r_tilt_x >= -atilt_pkg::TiltMax) &&
        (r_tilt_y <= atilt_pkg::TiltMax) && (r_tilt_y >= -atilt_pkg::TiltMax))
    `ATU_ASSERT_IMP(a_sign_match, i_clk, i_rst_n, r_v3,
        !((r_x_milli > 0) && (r_tilt_x < 0)) && !((r_x_milli < 0) && (r_tilt_x > 0)))
    `ATU_ASSERT_IMP(a_saturate, i_clk, i_rst_n, r_v3 && (r_y_milli > atilt_pkg::MilliScale),
        r_tilt_y == atilt_pkg::TiltMax)
    `ATU_ASSERT_IMP(a_full_stall, i_clk, i_rst_n,
        r_v1 && r_v2 && r_v3 && !o_result.ready, !i_sample.ready)

endmodule
